>>> hw/rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define RSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define RSC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hw/rtl/rsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsc_pkg;

    localparam int MEM_WORDS_DEF = 8192;
    localparam int WORD_W        = 16;
    localparam int ADDR_W        = 13;
    localparam int REG_AW        = 3;
    localparam int REG_COUNT     = 8;

    localparam logic [REG_AW-1:0] REG_ZERO = 3'd0;
    localparam logic [REG_AW-1:0] REG_LINK = 3'd7;

    typedef enum logic [1:0] {
        ACT_WRITE    = 2'd0,
        ACT_EXEC     = 2'd1,
        ACT_READ_REG = 2'd2,
        ACT_READ_MEM = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        OP_ALU  = 3'd0,
        OP_SLTI = 3'd1,
        OP_J    = 3'd2,
        OP_JAL  = 3'd3,
        OP_LW   = 3'd4,
        OP_SW   = 3'd5,
        OP_JEQ  = 3'd6,
        OP_ADDI = 3'd7
    } opcode_t;

    localparam logic [3:0] FN_ADD = 4'd0;
    localparam logic [3:0] FN_SUB = 4'd1;
    localparam logic [3:0] FN_OR  = 4'd2;
    localparam logic [3:0] FN_AND = 4'd3;
    localparam logic [3:0] FN_SLT = 4'd4;
    localparam logic [3:0] FN_JR  = 4'd8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_DATA,
        S_DECODE,
        S_EXEC,
        S_LOAD
    } state_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] address;
        logic [WORD_W-1:0] data;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic [WORD_W-1:0] program_counter;
        logic              halted;
    } rsp_t;

    // effects of one executed instruction
    typedef struct packed {
        logic              rf_we;
        logic [REG_AW-1:0] rf_waddr;
        logic [WORD_W-1:0] rf_wdata;
        logic              mem_we;
        logic              mem_rd;
        logic [ADDR_W-1:0] mem_addr;
        logic [WORD_W-1:0] mem_wdata;
        logic [WORD_W-1:0] pc_next;
        logic              halt_set;
    } exec_res_t;

    function automatic logic [WORD_W-1:0] sext7(input logic [6:0] v);
        return {{(WORD_W-7){v[6]}}, v};
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rsc_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module rsc_mem #(
    parameter int MEM_WORDS = rsc_pkg::MEM_WORDS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic                         re,
    input  wire logic [$clog2(MEM_WORDS)-1:0] addr,
    input  wire logic [rsc_pkg::WORD_W-1:0]   wdata,
    output logic      [rsc_pkg::WORD_W-1:0]   rdata
);
    import rsc_pkg::*;

    logic [WORD_W-1:0] store_reg [MEM_WORDS];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rsc_rf.sv
`timescale 1ns / 1ps
`default_nettype none

module rsc_rf (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       re,
    input  wire logic [rsc_pkg::REG_AW-1:0] raddr_a,
    input  wire logic [rsc_pkg::REG_AW-1:0] raddr_b,
    output logic      [rsc_pkg::WORD_W-1:0] rdata_a,
    output logic      [rsc_pkg::WORD_W-1:0] rdata_b,
    input  wire logic                       we,
    input  wire logic [rsc_pkg::REG_AW-1:0] waddr,
    input  wire logic [rsc_pkg::WORD_W-1:0] wdata
);
    import rsc_pkg::*;

    logic [REG_COUNT-1:0] valid_reg;
    logic [WORD_W-1:0]    words_reg [REG_COUNT];
    logic [WORD_W-1:0]    rdata_a_reg;
    logic [WORD_W-1:0]    rdata_b_reg;
    logic                 wr_en;

    // register zero is never stored, so it always reads as zero
    assign wr_en = we && (waddr != REG_ZERO);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            words_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= valid_reg[raddr_a] ? words_reg[raddr_a] : '0;
            rdata_b_reg <= valid_reg[raddr_b] ? words_reg[raddr_b] : '0;
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rsc_exec.sv
`timescale 1ns / 1ps
`default_nettype none

module rsc_exec (
    input  wire logic [rsc_pkg::WORD_W-1:0] ins,
    input  wire logic [rsc_pkg::WORD_W-1:0] pc,
    input  wire logic [rsc_pkg::WORD_W-1:0] a,
    input  wire logic [rsc_pkg::WORD_W-1:0] b,
    output rsc_pkg::exec_res_t              res
);
    import rsc_pkg::*;

    opcode_t           op;
    logic [3:0]        fn;
    logic [WORD_W-1:0] imm;
    logic [WORD_W-1:0] pc_inc;
    logic [WORD_W-1:0] target;
    logic [WORD_W-1:0] a_plus_imm;

    assign op         = opcode_t'(ins[15:13]);
    assign fn         = ins[3:0];
    assign imm        = sext7(ins[6:0]);
    assign pc_inc     = pc + 16'd1;
    assign target     = {{(WORD_W-ADDR_W){1'b0}}, ins[ADDR_W-1:0]};
    assign a_plus_imm = a + imm;

    always_comb
    begin
        res           = '0;
        res.rf_waddr  = ins[9:7];
        res.mem_addr  = a_plus_imm[ADDR_W-1:0];
        res.mem_wdata = b;
        res.pc_next   = pc_inc;
        unique case (op)
            OP_ALU:
            begin
                res.rf_waddr = ins[6:4];
                unique case (fn)
                    FN_ADD:
                    begin
                        res.rf_we    = 1'b1;
                        res.rf_wdata = a + b;
                    end
                    FN_SUB:
                    begin
                        res.rf_we    = 1'b1;
                        res.rf_wdata = a - b;
                    end
                    FN_OR:
                    begin
                        res.rf_we    = 1'b1;
                        res.rf_wdata = a | b;
                    end
                    FN_AND:
                    begin
                        res.rf_we    = 1'b1;
                        res.rf_wdata = a & b;
                    end
                    FN_SLT:
                    begin
                        res.rf_we    = 1'b1;
                        res.rf_wdata = {{(WORD_W-1){1'b0}}, (a < b)};
                    end
                    FN_JR:
                    begin
                        res.pc_next = a;
                    end
                    default:
                    begin
                        // unknown function: only pc moves on
                        res.rf_we = 1'b0;
                    end
                endcase
            end
            OP_SLTI:
            begin
                res.rf_we    = 1'b1;
                res.rf_wdata = {{(WORD_W-1){1'b0}}, (a < imm)};
            end
            OP_J:
            begin
                res.pc_next  = target;
                res.halt_set = (target == pc);
            end
            OP_JAL:
            begin
                res.rf_we    = 1'b1;
                res.rf_waddr = REG_LINK;
                res.rf_wdata = pc_inc;
                res.pc_next  = target;
            end
            OP_LW:
            begin
                res.mem_rd = 1'b1;
            end
            OP_SW:
            begin
                res.mem_we = 1'b1;
            end
            OP_JEQ:
            begin
                if (a == b)
                begin
                    res.pc_next = pc_inc + imm;
                end
            end
            OP_ADDI:
            begin
                res.rf_we    = 1'b1;
                res.rf_wdata = a_plus_imm;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/sixteen_bit_risc_core_step.sv
`timescale 1ns / 1ps
`default_nettype none
// 16-bit eight-register core driven one request item at a time
// req channel: action, address, data; one rsp item comes back for every req item
// rsp channel: read_data (register or memory word, else zero), pc and halted after the item
// steps from acceptance to the rsp item loaded into the output register, by control state:
//   memory write: issue; register or memory read: issue, data;
//   execute: issue, decode, exec; lw: issue, decode, exec, load; execute while halted: issue
// the next req item is taken on the same edge that loads the rsp of the previous one,
//   so items never overlap and a steady stream of executes runs each item through the
//   fetch read of the main memory, then the register file read, then execute
// both memories have a registered read; architectural state lives in them plus pc and halt
// reset clears pc, halt, the control state and the register file valid bits at once;
//   no clearing pass, items are accepted right after reset
// main memory contents are undefined until written
// a stalled rsp channel holds the finished item in the output register; the core
//   keeps its last step pending (no side effects) until the register frees up
module sixteen_bit_risc_core_step #(
    parameter int MEM_WORDS = rsc_pkg::MEM_WORDS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_ready,
    input  wire rsc_pkg::req_t req,
    output logic              rsp_valid,
    input  wire logic         rsp_ready,
    output rsc_pkg::rsp_t     rsp
);
    import rsc_pkg::*;

`include "assert_macros.svh"

    localparam int MEM_AW = $clog2(MEM_WORDS);

    // control and architectural state
    state_t            state_reg;
    state_t            state_next;
    req_t              item_reg;
    logic [WORD_W-1:0] pc_reg;
    logic              halt_reg;
    logic [WORD_W-1:0] ins_reg;
    logic [REG_AW-1:0] lw_dst_reg;
    logic [WORD_W-1:0] lw_pc_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    // memory and register file ports
    logic              mem_we;
    logic              mem_re;
    logic [MEM_AW-1:0] mem_addr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] mem_q;
    logic              rf_re;
    logic [REG_AW-1:0] rf_addr_a;
    logic [REG_AW-1:0] rf_addr_b;
    logic [WORD_W-1:0] rf_q_a;
    logic [WORD_W-1:0] rf_q_b;
    logic              rf_we;
    logic [REG_AW-1:0] rf_waddr;
    logic [WORD_W-1:0] rf_wdata;

    exec_res_t         ex;
    action_t           act;
    logic              slot_free;
    logic              fin;
    logic              commit;
    logic              accept;
    logic [WORD_W-1:0] pc_upd;
    logic              halt_upd;
    logic [WORD_W-1:0] rd_upd;

    assign act       = action_t'(item_reg.action);
    assign slot_free = !rsp_valid_reg || rsp_ready;

    // last step of the current item: the one that loads the rsp item
    always_comb
    begin
        fin = 1'b0;
        unique case (state_reg)
            S_ISSUE:  fin = (act == ACT_WRITE) || ((act == ACT_EXEC) && halt_reg);
            S_DATA:   fin = 1'b1;
            S_EXEC:   fin = !ex.mem_rd;
            S_LOAD:   fin = 1'b1;
            default:  fin = 1'b0;
        endcase
    end

    assign commit    = fin && slot_free;
    assign req_ready = (state_reg == S_IDLE) || commit;
    assign accept    = req_valid && req_ready;

    rsc_exec u_exec (
        .ins (ins_reg),
        .pc  (pc_reg),
        .a   (rf_q_a),
        .b   (rf_q_b),
        .res (ex)
    );

    rsc_mem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_q)
    );

    rsc_rf u_rf (
        .clk     (clk),
        .rst_n   (rst_n),
        .re      (rf_re),
        .raddr_a (rf_addr_a),
        .raddr_b (rf_addr_b),
        .rdata_a (rf_q_a),
        .rdata_b (rf_q_b),
        .we      (rf_we),
        .waddr   (rf_waddr),
        .wdata   (rf_wdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (!fin)
                begin
                    state_next = (act == ACT_EXEC) ? S_DECODE : S_DATA;
                end
                else if (commit)
                begin
                    state_next = req_valid ? S_ISSUE : S_IDLE;
                end
            end
            S_DECODE:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (ex.mem_rd)
                begin
                    state_next = S_LOAD;
                end
                else if (commit)
                begin
                    state_next = req_valid ? S_ISSUE : S_IDLE;
                end
            end
            S_DATA, S_LOAD:
            begin
                if (commit)
                begin
                    state_next = req_valid ? S_ISSUE : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory, register file and commit controls
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = pc_reg[MEM_AW-1:0];
        mem_wdata = item_reg.data;
        rf_re     = 1'b0;
        rf_addr_a = item_reg.address[REG_AW-1:0];
        rf_addr_b = item_reg.address[REG_AW-1:0];
        rf_we     = 1'b0;
        rf_waddr  = ex.rf_waddr;
        rf_wdata  = ex.rf_wdata;
        pc_upd    = pc_reg;
        halt_upd  = halt_reg;
        rd_upd    = '0;
        unique case (state_reg)
            S_ISSUE:
            begin
                unique case (act)
                    ACT_WRITE:
                    begin
                        mem_we   = commit;
                        mem_addr = item_reg.address[MEM_AW-1:0];
                    end
                    ACT_EXEC:
                    begin
                        // fetch; a halted core ignores the request
                        mem_re = !halt_reg;
                    end
                    ACT_READ_REG:
                    begin
                        rf_re = 1'b1;
                    end
                    ACT_READ_MEM:
                    begin
                        mem_re   = 1'b1;
                        mem_addr = item_reg.address[MEM_AW-1:0];
                    end
                endcase
            end
            S_DATA:
            begin
                rd_upd = (act == ACT_READ_REG) ? rf_q_a : mem_q;
            end
            S_DECODE:
            begin
                // operand read straight off the fetched word
                rf_re     = 1'b1;
                rf_addr_a = mem_q[12:10];
                rf_addr_b = mem_q[9:7];
            end
            S_EXEC:
            begin
                mem_addr  = ex.mem_addr[MEM_AW-1:0];
                mem_wdata = ex.mem_wdata;
                if (ex.mem_rd)
                begin
                    mem_re = 1'b1;
                end
                else
                begin
                    mem_we   = commit && ex.mem_we;
                    rf_we    = commit && ex.rf_we;
                    pc_upd   = ex.pc_next;
                    halt_upd = halt_reg || ex.halt_set;
                end
            end
            S_LOAD:
            begin
                rf_we    = commit;
                rf_waddr = lw_dst_reg;
                rf_wdata = mem_q;
                pc_upd   = lw_pc_reg;
            end
            default:
            begin
                rd_upd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            // decoder input starts from a known word
            ins_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DECODE)
            begin
                ins_reg <= mem_q;
            end
            if (commit)
            begin
                pc_reg        <= pc_upd;
                halt_reg      <= halt_upd;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
        if ((state_reg == S_EXEC) && ex.mem_rd)
        begin
            lw_dst_reg <= ex.rf_waddr;
            lw_pc_reg  <= ex.pc_next;
        end
        if (commit)
        begin
            rsp_reg.read_data       <= rd_upd;
            rsp_reg.program_counter <= pc_upd;
            rsp_reg.halted          <= halt_upd;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `RSC_ASSERT(a_accept_issues, accept |=> (state_reg == S_ISSUE), "accepted item not issued")
    `RSC_ASSERT(a_halt_sticky, halt_reg |=> halt_reg, "halt flag cleared")
    `RSC_NEVER(a_mem_one_access, mem_we && mem_re, "memory read and write in one cycle")
    `RSC_NEVER(a_rsp_no_overwrite, commit && rsp_valid_reg && !rsp_ready, "rsp item lost")

endmodule

`default_nettype wire
